// ===== rtl/lwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants for the LZSS window decoder: the beat formats
// of the input and result channels, status codes, register indexes and the
// window geometry.
// ----------------------------------------------------------------------------
package lwd_pkg;

	// Window geometry. The window is fixed at 4096 bytes.
	localparam int WINDOW_SIZE = 4096;
	localparam int WIN_AW      = $clog2(WINDOW_SIZE);
	localparam int MAX_MATCH   = 18;
	localparam int MIN_MATCH   = 3;

	// Default width of the output byte counter.
	localparam int COUNT_WIDTH_DEF = 32;

	// Write position after reset and the fill byte of an unwritten window entry.
	localparam logic [WIN_AW-1:0] WPOS_INIT = WIN_AW'(WINDOW_SIZE - MAX_MATCH);
	localparam logic [7:0]        FILL_BYTE = 8'h20;

	// Status codes carried in every result beat.
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_CLEAN = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_EXPECTED  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SIZE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HAS_LIMIT     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = CFG_IDX_W'(3);

	// One compressed byte or the end-of-input marker.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} lwd_in_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       last;
	} lwd_out_t;

endpackage

// ===== rtl/lzss_window_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_window_decoder
// Streaming LZSS decompressor with a 4096-byte history window, optional
// expected-size and output-limit checks, and a sticky end status.
// ----------------------------------------------------------------------------
// Each input beat is registered in the idle state and evaluated in the
// evaluation state once the result slot is free. The second byte of a match
// starts a copy of 3 to 18 bytes: the copy loop runs at one byte per cycle
// through the window's single read port, with a bypass for a byte that is
// read back in the cycle it is written. A stall on the result side pauses
// the loop. Input is refused while a beat is being worked on. The window
// needs no clearing pass after reset: a fill count tracks which entries
// have been written, and any other entry reads as a space. The length of a
// token is checked against the expected size and the limit by one shared
// adder and two comparators before any of its bytes go out.
module lzss_window_decoder #(
	parameter int COUNT_WIDTH = lwd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  lwd_pkg::lwd_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lwd_pkg::lwd_out_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lwd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);
	import lwd_pkg::*;

	localparam int CMP_W  = (COUNT_WIDTH + 1 > 33) ? COUNT_WIDTH + 1 : 33;
	localparam int FILL_W = WIN_AW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COPY
	} state_t;

	// Registers.
	state_t                  state_q;
	logic [7:0]              byte_q;
	logic                    eoi_q;
	logic                    has_exp_q;
	logic [31:0]             exp_size_q;
	logic                    has_lim_q;
	logic [31:0]             out_limit_q;
	logic [WIN_AW-1:0]       write_pos_q;
	logic [7:0]              flag_bits_q;
	logic [3:0]              flag_idx_q;
	logic                    phase_q;
	logic [7:0]              pos_low_q;
	logic [WIN_AW-1:0]       copy_pos_q;
	logic [4:0]              remain_q;
	logic [COUNT_WIDTH-1:0]  produced_q;
	logic                    finished_q;
	logic [1:0]              end_code_q;
	logic [FILL_W-1:0]       fill_q;
	logic                    out_valid_q;
	lwd_out_t                out_q;

	// Window memory and its read pipeline.
	logic [7:0]              window_mem [WINDOW_SIZE];
	logic [7:0]              mem_rd_q;
	logic                    rd_hit_q;
	logic [7:0]              rd_fwd_q;
	logic                    rd_written_q;

	// Combinational controls.
	logic                    slot_free;
	logic [4:0]              match_len;
	logic [4:0]              need;
	logic [CMP_W-1:0]        sum;
	logic                    fits;
	logic                    at_size;
	logic                    flag_bit;
	logic [7:0]              copy_byte;
	logic                    we;
	logic [WIN_AW-1:0]       waddr;
	logic [7:0]              wdata;
	logic                    re;
	logic [WIN_AW-1:0]       raddr;
	logic [WIN_AW-1:0]       match_pos;
	logic [WIN_AW-1:0]       rd_offset;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Shared size check: one adder and two compares serve literals and matches.
	assign match_len = {1'b0, byte_q[3:0]} + 5'(MIN_MATCH);
	assign need      = phase_q ? match_len : 5'd1;
	assign sum       = CMP_W'(produced_q) + CMP_W'(need);
	assign fits      = (sum[CMP_W-1:COUNT_WIDTH] == '0)
		&& !(has_exp_q && (sum > CMP_W'(exp_size_q)))
		&& !(has_lim_q && (sum > CMP_W'(out_limit_q)));
	assign at_size   = has_exp_q && (CMP_W'(produced_q) == CMP_W'(exp_size_q));
	assign flag_bit  = flag_bits_q[flag_idx_q[2:0]];

	// Byte coming out of the read pipeline: bypass, written entry or fill byte.
	assign copy_byte = rd_hit_q ? rd_fwd_q : (rd_written_q ? mem_rd_q : FILL_BYTE);
	assign match_pos = {byte_q[7:4], pos_low_q};

	// Window port control.
	always_comb begin
		waddr = write_pos_q;
		wdata = copy_byte;
		we    = 1'b0;
		re    = 1'b0;
		raddr = copy_pos_q;
		if (state_q == S_EVAL && slot_free && !finished_q && !eoi_q
			&& !(!phase_q && at_size) && !flag_idx_q[3] && fits) begin
			if (!phase_q && flag_bit) begin
				we    = 1'b1;
				wdata = byte_q;
			end else if (phase_q) begin
				re    = 1'b1;
				raddr = match_pos;
			end
		end else if (state_q == S_COPY && slot_free) begin
			we = 1'b1;
			re = 1'b1;
		end
	end

	// Entry is written if it lies within the first fill_q positions of the write order.
	assign rd_offset = raddr - WPOS_INIT;

	// Window storage with a registered read and a same-cycle write bypass.
	always_ff @(posedge clk) begin
		if (we) begin
			window_mem[waddr] <= wdata;
		end
		if (re) begin
			mem_rd_q     <= window_mem[raddr];
			rd_hit_q     <= we && (raddr == waddr);
			rd_fwd_q     <= wdata;
			rd_written_q <= {1'b0, rd_offset} < fill_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_exp_q   <= 1'b0;
			exp_size_q  <= '0;
			has_lim_q   <= 1'b0;
			out_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HAS_EXPECTED:  has_exp_q   <= cfg_data[0];
				REG_EXPECTED_SIZE: exp_size_q  <= cfg_data;
				REG_HAS_LIMIT:     has_lim_q   <= cfg_data[0];
				REG_OUTPUT_LIMIT:  out_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with the decoder state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			byte_q      <= '0;
			eoi_q       <= 1'b0;
			write_pos_q <= WPOS_INIT;
			flag_bits_q <= '0;
			flag_idx_q  <= 4'd8;
			phase_q     <= 1'b0;
			pos_low_q   <= '0;
			copy_pos_q  <= '0;
			remain_q    <= '0;
			produced_q  <= '0;
			finished_q  <= 1'b0;
			end_code_q  <= ST_RUN;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Every window write advances the position and the count, and the fill until it saturates.
			if (we) begin
				write_pos_q <= write_pos_q + 1'b1;
				produced_q  <= produced_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW_SIZE)) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q  <= in_data.in_byte;
						eoi_q   <= in_data.end_of_input;
						state_q <= S_EVAL;
					end
				end

				S_EVAL: begin
					if (slot_free) begin
						state_q            <= S_IDLE;
						out_valid_q        <= 1'b1;
						out_q.out_byte     <= '0;
						out_q.byte_valid   <= 1'b0;
						out_q.status       <= ST_RUN;
						out_q.last         <= 1'b1;
						if (finished_q) begin
							out_q.status <= end_code_q;
						end else if (eoi_q) begin
							finished_q <= 1'b1;
							if (phase_q || (has_exp_q && !at_size)) begin
								end_code_q   <= ST_ERROR;
								out_q.status <= ST_ERROR;
							end else begin
								end_code_q   <= ST_CLEAN;
								out_q.status <= ST_CLEAN;
							end
						end else if (!phase_q && at_size) begin
							finished_q   <= 1'b1;
							end_code_q   <= ST_ERROR;
							out_q.status <= ST_ERROR;
						end else if (flag_idx_q[3]) begin
							flag_bits_q <= byte_q;
							flag_idx_q  <= '0;
						end else if (!phase_q && !flag_bit) begin
							pos_low_q <= byte_q;
							phase_q   <= 1'b1;
						end else if (!fits) begin
							phase_q      <= 1'b0;
							finished_q   <= 1'b1;
							end_code_q   <= ST_ERROR;
							out_q.status <= ST_ERROR;
						end else if (!phase_q) begin
							// Literal byte.
							out_q.out_byte   <= byte_q;
							out_q.byte_valid <= 1'b1;
							flag_idx_q       <= flag_idx_q + 1'b1;
						end else begin
							// Match accepted: first read is under way, copy loop follows.
							out_valid_q <= 1'b0;
							phase_q     <= 1'b0;
							flag_idx_q  <= flag_idx_q + 1'b1;
							copy_pos_q  <= match_pos + 1'b1;
							remain_q    <= match_len;
							state_q     <= S_COPY;
						end
					end
				end

				S_COPY: begin
					if (slot_free) begin
						out_valid_q      <= 1'b1;
						out_q.out_byte   <= copy_byte;
						out_q.byte_valid <= 1'b1;
						out_q.status     <= ST_RUN;
						out_q.last       <= (remain_q == 5'd1);
						copy_pos_q       <= copy_pos_q + 1'b1;
						remain_q         <= remain_q - 1'b1;
						if (remain_q == 5'd1) begin
							state_q <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The write position always trails the output count from its start point.
	a_wpos_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		write_pos_q == WIN_AW'(WPOS_INIT + produced_q[WIN_AW-1:0]))
		else $error("write position out of step with output count");

	// The fill count saturates at the window size.
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_SIZE))
		else $error("window fill count overran");

	// The copy loop always has bytes left to send.
	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (remain_q != '0 && remain_q <= 5'(MAX_MATCH)))
		else $error("copy loop with bad remaining length");

	// Once finished, no decoded byte is offered.
	a_no_bytes_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && out_valid_q) |-> !out_q.byte_valid)
		else $error("decoded byte after end status");

	// The copy loop is only entered from evaluation, where the match length is checked.
	a_copy_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY && $past(state_q) != S_COPY) |-> $past(state_q) == S_EVAL)
		else $error("copy loop entered without evaluation");

endmodule
